// ===== rtl/core/ptm_pkg.sv =====
`default_nettype none
package ptm_pkg;

    localparam int TABLE_FRAMES_DEF = 64;
    localparam int ENTRIES          = 512;
    localparam int IDX_W            = 9;
    localparam int VA_W             = 57;
    localparam int PA_W             = 52;
    localparam int BASE_W           = 40;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GIG_PAGES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE  = 2'd2;

    localparam logic [1:0] SIZE_4K   = 2'd0;
    localparam logic [1:0] SIZE_2M   = 2'd1;
    localparam logic [1:0] SIZE_1G   = 2'd2;
    localparam logic [1:0] SIZE_NONE = 2'd3;

    localparam logic [2:0] LVL_PT   = 3'd0;
    localparam logic [2:0] LVL_PD   = 3'd1;
    localparam logic [2:0] LVL_PDPT = 3'd2;
    localparam logic [2:0] LVL_PML4 = 3'd3;
    localparam logic [2:0] LVL_PML5 = 3'd4;

    localparam logic [63:0] LARGE_BIT = 64'h80;
    localparam logic [63:0] LOW12     = 64'hFFF;
    localparam logic [2:0]  LINK_BITS = 3'b111;
    localparam logic [VA_W-1:0] SPAN_2M = 57'h200000;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNMAPPED = 3'd1,
        ST_NOFRAME  = 3'd2,
        ST_LARGE    = 3'd3,
        ST_BADPTR   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_LEAF,
        S_FIN
    } fsm_t;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    descend;
        logic    link;
        logic    zero;
        logic    clr;
        logic    leaf;
        logic    next_sub;
        logic    finish;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic zero_done;
        logic map_at_target;
        logic xlate;
        logic level_zero;
        logic present;
        logic large_stop;
        logic bad_ptr;
        logic no_frame;
        logic split_more;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptm_if.sv =====
`default_nettype none
interface ptm_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [56:0] vaddr;
    logic [51:0] paddr;
    logic [63:0] flags;
    logic [1:0]  leaf_size;

    modport source (output valid, output operation, output vaddr, output paddr,
                    output flags, output leaf_size, input ready);
    modport sink   (input valid, input operation, input vaddr, input paddr,
                    input flags, input leaf_size, output ready);
endinterface

interface ptm_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] leaf_address;
    logic [2:0]  status;

    modport source (output valid, output leaf_address, output status, input ready);
    modport sink   (input valid, input leaf_address, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/page_table_map_and_translate_core.sv =====
`default_nettype none
// Page table map/translate engine.
// req carries one request: operation 0 maps (or unmaps) a page of leaf_size,
// operation 1 translates vaddr. rsp returns exactly one result per
// request, in order: leaf_address (translate only) and status.
// Registers are written on cfg_write_en with cfg_index/cfg_data; the user
// must write them only while idle, as the block has no check for it.
// One request is processed at a time. Each table level is a store read,
// then a decode; the result is registered in a final state after the
// last decode, which waits while rsp still holds an earlier result, and
// the next request is taken back in idle. Every table created by a map
// adds 512 clearing writes plus the link write.
// A 1GiB map with large pages off runs 512 2MiB sub-walks back to back.
// After reset all TABLE_FRAMES*512 entries of the table store are cleared
// one entry per cycle, with req.ready low; config writes are taken.
// rsp has an output register: a new request is accepted while a result
// waits; if rsp stalls, the following result holds its walk until taken.
module page_table_map_and_translate_core #(
    parameter int TABLE_FRAMES = ptm_pkg::TABLE_FRAMES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ptm_req_if.sink                             req,
    ptm_rsp_if.source                           rsp,
    input  wire logic                           cfg_write_en,
    input  wire logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptm_pkg::CFG_DATA_W-1:0] cfg_data
);

    ptm_pkg::cmd_t     cmd;
    ptm_pkg::dp_stat_t stat;
    logic              in_ready;

    assign req.ready = in_ready;

    ptm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ptm_datapath #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .operation    (req.operation),
        .vaddr        (req.vaddr),
        .paddr        (req.paddr),
        .flags        (req.flags),
        .leaf_size    (req.leaf_size),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .rsp          (rsp)
    );

endmodule
`default_nettype wire

// ===== rtl/core/ptm_datapath.sv =====
`default_nettype none
module ptm_datapath #(
    parameter int TABLE_FRAMES = ptm_pkg::TABLE_FRAMES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              operation,
    input  wire logic [ptm_pkg::VA_W-1:0]          vaddr,
    input  wire logic [ptm_pkg::PA_W-1:0]          paddr,
    input  wire logic [63:0]                       flags,
    input  wire logic [1:0]                        leaf_size,
    input  wire logic                              cfg_write_en,
    input  wire logic [ptm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire ptm_pkg::cmd_t                     cmd,
    output ptm_pkg::dp_stat_t                      stat,
    ptm_rsp_if.source                              rsp
);

    localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NFW   = $clog2(TABLE_FRAMES + 1);
    localparam int AW    = FW + ptm_pkg::IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ptm_pkg::ENTRIES;
    localparam int LAST  = DEPTH - 1;

    logic [63:0] mem [DEPTH];

    logic                          five_reg, gig_reg;
    logic [ptm_pkg::BASE_W-1:0]    base_reg;
    logic                          op_reg, split_reg;
    logic [ptm_pkg::VA_W-1:0]      va_reg;
    logic [ptm_pkg::PA_W:0]        pa_reg;
    logic [63:0]                   flags_reg;
    logic [2:0]                    target_reg, level_reg;
    logic [FW-1:0]                 frame_reg;
    logic [NFW-1:0]                nf_reg;
    logic [8:0]                    k_reg, zcnt_reg;
    logic [AW-1:0]                 clr_reg;
    logic [63:0]                   rd_reg;
    logic                          out_valid_reg;
    logic [63:0]                   leaf_reg;
    ptm_pkg::status_t              status_reg;

    logic [ptm_pkg::IDX_W-1:0]     idx;
    logic [AW-1:0]                 addr, wa;
    logic [63:0]                   wd, link_val, leaf_val;
    logic                          we;
    logic [FW-1:0]                 new_frame;
    logic [ptm_pkg::BASE_W-1:0]    ptr40, link_page;
    logic [1:0]                    size_n;
    logic [2:0]                    start_level;

    always_comb
    begin
        case (level_reg)
            ptm_pkg::LVL_PT:   idx = va_reg[20:12];
            ptm_pkg::LVL_PD:   idx = va_reg[29:21];
            ptm_pkg::LVL_PDPT: idx = va_reg[38:30];
            ptm_pkg::LVL_PML4: idx = va_reg[47:39];
            default:           idx = va_reg[56:48];
        endcase
    end

    assign addr        = {frame_reg, idx};
    assign new_frame   = nf_reg[FW-1:0];
    assign ptr40       = rd_reg[51:12] - base_reg;
    assign link_page   = base_reg + ptm_pkg::BASE_W'(new_frame);
    assign link_val    = {12'b0, link_page, 9'b0, ptm_pkg::LINK_BITS};
    assign leaf_val    = {11'b0, pa_reg} | flags_reg
                       | ((target_reg != ptm_pkg::LVL_PT) ? ptm_pkg::LARGE_BIT : 64'b0);
    assign size_n      = (leaf_size == ptm_pkg::SIZE_NONE) ? ptm_pkg::SIZE_4K : leaf_size;
    assign start_level = five_reg ? ptm_pkg::LVL_PML5 : ptm_pkg::LVL_PML4;

    always_comb
    begin
        we = 1'b1;
        wa = addr;
        wd = 64'b0;
        if (cmd.clr)
        begin
            wa = clr_reg;
        end
        else if (cmd.zero)
        begin
            wa = {new_frame, zcnt_reg};
        end
        else if (cmd.link)
        begin
            wd = link_val;
        end
        else if (cmd.leaf)
        begin
            wd = leaf_val;
        end
        else
        begin
            we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_comb
    begin
        stat.clr_done      = (clr_reg == AW'(LAST));
        stat.zero_done     = (zcnt_reg == 9'h1FF);
        stat.map_at_target = !op_reg && (level_reg == target_reg);
        stat.xlate         = op_reg;
        stat.level_zero    = (level_reg == ptm_pkg::LVL_PT);
        stat.present       = rd_reg[0];
        stat.large_stop    = ((level_reg == ptm_pkg::LVL_PDPT) || (level_reg == ptm_pkg::LVL_PD))
                             && rd_reg[7];
        stat.bad_ptr       = (ptr40 >= ptm_pkg::BASE_W'(TABLE_FRAMES));
        stat.no_frame      = (nf_reg >= NFW'(TABLE_FRAMES));
        stat.split_more    = split_reg && (k_reg != 9'h1FF);
        stat.out_busy      = out_valid_reg && !rsp.ready;
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            va_reg     <= vaddr;
            pa_reg     <= {1'b0, paddr};
            flags_reg  <= flags;
            split_reg  <= (size_n == ptm_pkg::SIZE_1G) && !gig_reg;
            target_reg <= (size_n == ptm_pkg::SIZE_4K) ? ptm_pkg::LVL_PT :
                          ((size_n == ptm_pkg::SIZE_2M) || !gig_reg) ? ptm_pkg::LVL_PD
                                                                     : ptm_pkg::LVL_PDPT;
            level_reg  <= start_level;
            frame_reg  <= '0;
            k_reg      <= 9'd0;
        end
        else if (cmd.next_sub)
        begin
            va_reg    <= va_reg + ptm_pkg::SPAN_2M;
            pa_reg    <= pa_reg + (ptm_pkg::PA_W+1)'(ptm_pkg::SPAN_2M);
            level_reg <= start_level;
            frame_reg <= '0;
            k_reg     <= k_reg + 9'd1;
        end
        else if (cmd.descend)
        begin
            frame_reg <= ptr40[FW-1:0];
            level_reg <= level_reg - 3'd1;
        end
        else if (cmd.link)
        begin
            frame_reg <= new_frame;
            level_reg <= level_reg - 3'd1;
        end
        if (cmd.finish)
        begin
            leaf_reg   <= (op_reg && (cmd.code == ptm_pkg::ST_OK)) ? (rd_reg & ~ptm_pkg::LOW12)
                                                                    : 64'b0;
            status_reg <= cmd.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            five_reg      <= 1'b0;
            gig_reg       <= 1'b1;
            base_reg      <= '0;
            nf_reg        <= NFW'(1);
            clr_reg       <= '0;
            zcnt_reg      <= 9'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    ptm_pkg::CFG_FIVE_LEVEL: five_reg <= cfg_data[0];
                    ptm_pkg::CFG_GIG_PAGES:  gig_reg  <= cfg_data[0];
                    ptm_pkg::CFG_BASE_PAGE:  base_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.zero)
            begin
                zcnt_reg <= zcnt_reg + 9'd1;
            end
            if (cmd.link)
            begin
                nf_reg <= nf_reg + NFW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.leaf_address = leaf_reg;
    assign rsp.status       = status_reg;

`ifndef ASSERT_OFF
    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg <= NFW'(TABLE_FRAMES))
        else $error("free frame count beyond store");

    a_leaf_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (leaf_reg != 64'b0)) |-> (status_reg == ptm_pkg::ST_OK))
        else $error("nonzero leaf with failing status");

    a_link_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> (nf_reg < NFW'(TABLE_FRAMES)))
        else $error("link written with no free frame");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd || cmd.leaf) |-> (level_reg <= ptm_pkg::LVL_PML5))
        else $error("walk level out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ptm_ctrl.sv =====
`default_nettype none
module ptm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ptm_pkg::dp_stat_t stat,
    output ptm_pkg::cmd_t          cmd
);

    ptm_pkg::fsm_t    state_reg, state_next;
    ptm_pkg::status_t code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        unique case (state_reg)
            ptm_pkg::S_CLEAR:
            begin
                if (stat.clr_done)
                begin
                    state_next = ptm_pkg::S_IDLE;
                end
            end
            ptm_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ptm_pkg::S_READ;
                end
            end
            ptm_pkg::S_READ:
            begin
                state_next = stat.map_at_target ? ptm_pkg::S_LEAF : ptm_pkg::S_EVAL;
            end
            ptm_pkg::S_EVAL:
            begin
                state_next = ptm_pkg::S_FIN;
                if (stat.xlate && stat.level_zero)
                begin
                    code_next = stat.present ? ptm_pkg::ST_OK : ptm_pkg::ST_UNMAPPED;
                end
                else if (stat.present)
                begin
                    if (stat.large_stop)
                    begin
                        code_next = ptm_pkg::ST_LARGE;
                    end
                    else if (stat.bad_ptr)
                    begin
                        code_next = ptm_pkg::ST_BADPTR;
                    end
                    else
                    begin
                        state_next = ptm_pkg::S_READ;
                    end
                end
                else if (stat.xlate)
                begin
                    code_next = ptm_pkg::ST_UNMAPPED;
                end
                else if (stat.no_frame)
                begin
                    code_next = ptm_pkg::ST_NOFRAME;
                end
                else
                begin
                    state_next = ptm_pkg::S_ZERO;
                end
            end
            ptm_pkg::S_ZERO:
            begin
                if (stat.zero_done)
                begin
                    state_next = ptm_pkg::S_LINK;
                end
            end
            ptm_pkg::S_LINK:
            begin
                state_next = ptm_pkg::S_READ;
            end
            ptm_pkg::S_LEAF:
            begin
                if (stat.split_more)
                begin
                    state_next = ptm_pkg::S_READ;
                end
                else
                begin
                    state_next = ptm_pkg::S_FIN;
                    code_next  = ptm_pkg::ST_OK;
                end
            end
            ptm_pkg::S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ptm_pkg::S_IDLE;
                end
            end
            default: state_next = ptm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.code = code_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            ptm_pkg::S_CLEAR: cmd.clr = 1'b1;
            ptm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ptm_pkg::S_READ:  cmd.rd = !stat.map_at_target;
            ptm_pkg::S_EVAL:
            begin
                cmd.descend = stat.present && !stat.large_stop && !stat.bad_ptr
                              && !(stat.xlate && stat.level_zero);
            end
            ptm_pkg::S_ZERO:  cmd.zero = 1'b1;
            ptm_pkg::S_LINK:  cmd.link = 1'b1;
            ptm_pkg::S_LEAF:
            begin
                cmd.leaf     = 1'b1;
                cmd.next_sub = stat.split_more;
            end
            ptm_pkg::S_FIN:   cmd.finish = !stat.out_busy;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptm_pkg::S_CLEAR;
            code_reg  <= ptm_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

`ifndef ASSERT_OFF
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr, cmd.zero, cmd.link, cmd.leaf}))
        else $error("two store writes in one cycle");

    a_link_after_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> $past(cmd.zero))
        else $error("link written before frame cleared");

    a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish)
        else $error("result loaded twice");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int          FRAMES     = ptm_pkg::TABLE_FRAMES_DEF;
    localparam int          ENTRIES    = ptm_pkg::ENTRIES;
    localparam logic        OP_MAP     = 1'b0;
    localparam logic        OP_XLATE   = 1'b1;
    localparam int          IDLE_LIMIT = 200000;
    localparam logic [39:0] BASE_MAX   = 40'hFF_FFFF_FFFF;

    typedef struct {
        logic [63:0]      leaf;
        ptm_pkg::status_t st;
    } walk_result_t;

    class walk_scoreboard;
        logic [63:0]    tables [0:FRAMES*ENTRIES-1];
        int unsigned    next_frame;
        bit             five_lvl;
        bit             gig_ok;
        logic [39:0]    base_page;
        walk_result_t   expected_q[$];
        int             mismatches;

        function new();
            foreach (tables[i]) tables[i] = '0;
            next_frame = 1;
            five_lvl   = 0;
            gig_ok     = 1;
            base_page  = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [ptm_pkg::CFG_IDX_W-1:0] idx,
                              logic [ptm_pkg::CFG_DATA_W-1:0] val);
            if (idx == ptm_pkg::CFG_FIVE_LEVEL) five_lvl = val[0];
            else if (idx == ptm_pkg::CFG_GIG_PAGES) gig_ok = val[0];
            else if (idx == ptm_pkg::CFG_BASE_PAGE) base_page = val[39:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function ptm_pkg::status_t descend(int unsigned fr, logic [8:0] idx, bit alloc,
                                           bit leaf_lvl, output int unsigned nxt);
            logic [63:0] ent;
            logic [39:0] f;
            int unsigned nf;
            nxt = fr;
            ent = tables[fr*ENTRIES + idx];
            if (ent[0])
            begin
                if (leaf_lvl && ent[7]) return ptm_pkg::ST_LARGE;
                f = ent[51:12] - base_page;
                if (f >= FRAMES) return ptm_pkg::ST_BADPTR;
                nxt = f[31:0];
                return ptm_pkg::ST_OK;
            end
            if (!alloc) return ptm_pkg::ST_UNMAPPED;
            if (next_frame >= FRAMES) return ptm_pkg::ST_NOFRAME;
            nf = next_frame;
            next_frame++;
            for (int i = 0; i < ENTRIES; i++) tables[nf*ENTRIES + i] = '0;
            f = base_page + 40'(nf);
            tables[fr*ENTRIES + idx] = {12'h0, f, 9'h0, ptm_pkg::LINK_BITS};
            nxt = nf;
            return ptm_pkg::ST_OK;
        endfunction

        function ptm_pkg::status_t walk_upper(logic [56:0] va, bit alloc,
                                              output int unsigned fr);
            ptm_pkg::status_t st;
            fr = 0;
            if (five_lvl)
            begin
                st = descend(fr, va[56:48], alloc, 0, fr);
                if (st != ptm_pkg::ST_OK) return st;
            end
            return descend(fr, va[47:39], alloc, 0, fr);
        endfunction

        function ptm_pkg::status_t map_page(logic [56:0] va, logic [63:0] pa,
                                            logic [63:0] fl, logic [1:0] sz);
            int unsigned      fr;
            ptm_pkg::status_t st;
            st = walk_upper(va, 1, fr);
            if (st != ptm_pkg::ST_OK) return st;
            if (sz == ptm_pkg::SIZE_1G)
            begin
                if (gig_ok)
                begin
                    tables[fr*ENTRIES + va[38:30]] = pa | fl | ptm_pkg::LARGE_BIT;
                    return ptm_pkg::ST_OK;
                end
                // split into 2MiB leaves, first failure ends it
                for (int k = 0; k < 512; k++)
                begin
                    st = map_page(va + ptm_pkg::SPAN_2M*k, pa + 64'(ptm_pkg::SPAN_2M)*k,
                                  fl, ptm_pkg::SIZE_2M);
                    if (st != ptm_pkg::ST_OK) return st;
                end
                return ptm_pkg::ST_OK;
            end
            st = descend(fr, va[38:30], 1, 1, fr);
            if (st != ptm_pkg::ST_OK) return st;
            if (sz == ptm_pkg::SIZE_2M)
            begin
                tables[fr*ENTRIES + va[29:21]] = pa | fl | ptm_pkg::LARGE_BIT;
                return ptm_pkg::ST_OK;
            end
            st = descend(fr, va[29:21], 1, 1, fr);
            if (st != ptm_pkg::ST_OK) return st;
            tables[fr*ENTRIES + va[20:12]] = pa | fl;
            return ptm_pkg::ST_OK;
        endfunction

        function walk_result_t translate(logic [56:0] va);
            walk_result_t r;
            int unsigned  fr;
            logic [63:0]  ent;
            r.leaf = '0;
            r.st = walk_upper(va, 0, fr);
            if (r.st != ptm_pkg::ST_OK) return r;
            r.st = descend(fr, va[38:30], 0, 1, fr);
            if (r.st != ptm_pkg::ST_OK) return r;
            r.st = descend(fr, va[29:21], 0, 1, fr);
            if (r.st != ptm_pkg::ST_OK) return r;
            ent = tables[fr*ENTRIES + va[20:12]];
            if (!ent[0])
            begin
                r.st = ptm_pkg::ST_UNMAPPED;
                return r;
            end
            r.leaf = ent & ~ptm_pkg::LOW12;
            return r;
        endfunction

        function void record_request(logic op, logic [56:0] va, logic [51:0] pa,
                                     logic [63:0] fl, logic [1:0] sz);
            walk_result_t r;
            if (op == OP_XLATE)
                r = translate(va);
            else
            begin
                r.leaf = '0;
                r.st = map_page(va, {12'h0, pa}, fl,
                                (sz == ptm_pkg::SIZE_NONE) ? ptm_pkg::SIZE_4K : sz);
            end
            expected_q.push_back(r);
        endfunction

        function void check_response(logic [63:0] leaf, logic [2:0] st);
            walk_result_t r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response leaf=%h status=%0d", leaf, st);
                return;
            end
            r = expected_q.pop_front();
            if (leaf !== r.leaf || st !== r.st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: leaf exp %h act %h, status exp %0d act %0d",
                             r.leaf, leaf, r.st, st);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ptm_pkg::CFG_DATA_W-1:0] cfg_data;
    bit req_burst;
    bit rsp_burst;
    int idle_cycles;
    walk_scoreboard sb;

    ptm_req_if req_if();
    ptm_rsp_if rsp_if();

    page_table_map_and_translate_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_if),
        .rsp          (rsp_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (req_if.valid && req_if.ready)
            sb.record_request(req_if.operation, req_if.vaddr, req_if.paddr,
                              req_if.flags, req_if.leaf_size);
        if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.leaf_address, rsp_if.status);
        if (cfg_write_en)
            sb.set_reg(cfg_index, cfg_data);
    end

    // watchdog: cycles with no request or response moving
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int delay;
        int cnt;
        rsp_if.ready <= 1'b0;
        cnt = 0;
        @(posedge rst_n);
        forever
        begin
            if (cnt % 25 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
            cnt++;
            delay = rsp_burst ? 0 : $urandom_range(0, 18);
            if (delay > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (delay) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    task automatic send_request(logic op, logic [56:0] va, logic [51:0] pa,
                                logic [63:0] fl, logic [1:0] sz);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.vaddr     <= va;
        req_if.paddr     <= pa;
        req_if.flags     <= fl;
        req_if.leaf_size <= sz;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic write_reg(logic [ptm_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptm_pkg::CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_mode(bit five, bit gig, logic [39:0] base);
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        write_reg(ptm_pkg::CFG_FIVE_LEVEL, ptm_pkg::CFG_DATA_W'(five));
        write_reg(ptm_pkg::CFG_GIG_PAGES, ptm_pkg::CFG_DATA_W'(gig));
        write_reg(ptm_pkg::CFG_BASE_PAGE, base);
    endtask

    function automatic logic [56:0] pick_va();
        logic [8:0]  l5, l4, l3, l2;
        logic [20:0] low;
        if ($urandom_range(0, 9) == 0) return 57'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: l5 = 9'd0;
            1: l5 = 9'd1;
            2: l5 = 9'd511;
            default: l5 = 9'($urandom);
        endcase
        l4 = ($urandom_range(0, 1) == 0) ? 9'd0 : 9'd511;
        case ($urandom_range(0, 2))
            0: l3 = 9'd0;
            1: l3 = 9'd1;
            default: l3 = 9'd511;
        endcase
        case ($urandom_range(0, 3))
            0: l2 = 9'd0;
            1: l2 = 9'd1;
            2: l2 = 9'd2;
            default: l2 = 9'd511;
        endcase
        low = 21'($urandom);
        return {l5, l4, l3, l2, low};
    endfunction

    task automatic random_requests(int count, bit gig_off);
        logic [63:0] fl;
        logic [1:0]  sz;
        int          r;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0) req_burst = ($urandom_range(0, 3) == 0);
            fl = {$urandom, $urandom};
            if ($urandom_range(0, 6) != 0) fl[0] = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 50) sz = ptm_pkg::SIZE_4K;
            else if (r < 78) sz = ptm_pkg::SIZE_2M;
            else if (r < (gig_off ? 81 : 90)) sz = ptm_pkg::SIZE_1G;
            else if (r < 95) sz = ptm_pkg::SIZE_NONE;
            else sz = ptm_pkg::SIZE_4K;
            send_request(($urandom_range(0, 1) == 0) ? OP_MAP : OP_XLATE, pick_va(),
                         52'({$urandom, $urandom}), fl, sz);
        end
    endtask

    initial
    begin
        logic [56:0] va_ones;
        sb = new();
        va_ones = '1;
        idle_cycles = 0;
        req_burst = 0;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        req_if.valid <= 1'b0;
        req_if.operation <= OP_MAP;
        req_if.vaddr <= '0;
        req_if.paddr <= '0;
        req_if.flags <= '0;
        req_if.leaf_size <= ptm_pkg::SIZE_4K;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(0, 1, '0);
        // directed: basic walks, large leaves, unmap, odd size, extremes
        send_request(OP_XLATE, 57'h0, '1, '1, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h0, 52'h1_2345_6789_A000, 64'h63, ptm_pkg::SIZE_4K);
        send_request(OP_XLATE, 57'h0, '0, '0, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h20_0000, 52'h4_0000_0000, 64'h3, ptm_pkg::SIZE_2M);
        send_request(OP_XLATE, 57'h20_1000, '0, '0, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h4000_0000, 52'h8_0000_0000, 64'h7, ptm_pkg::SIZE_1G);
        send_request(OP_XLATE, 57'h4000_5000, '0, '0, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h4000_5000, 52'h5000, 64'h3, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h20_0000, 52'h0, 64'h0, ptm_pkg::SIZE_2M);
        send_request(OP_MAP, 57'h0, 52'h0, 64'h2, ptm_pkg::SIZE_4K);
        send_request(OP_XLATE, 57'h0, '0, '0, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h3000, 52'hABC_D000, 64'h1, ptm_pkg::SIZE_NONE);
        send_request(OP_XLATE, 57'h3FFF, '0, '0, ptm_pkg::SIZE_NONE);
        send_request(OP_MAP, va_ones, '1, '1, ptm_pkg::SIZE_4K);
        send_request(OP_XLATE, va_ones, '0, '0, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, va_ones, '1, '1, ptm_pkg::SIZE_2M);
        send_request(OP_XLATE, va_ones, '1, '1, ptm_pkg::SIZE_1G);
        random_requests(140, 0);

        set_mode(0, 0, '0);
        send_request(OP_MAP, 57'h80_0000_0000, 52'h10_0000_0000, 64'h3, ptm_pkg::SIZE_1G);
        send_request(OP_XLATE, 57'h80_3FE0_0000, '0, '0, ptm_pkg::SIZE_4K);
        random_requests(100, 1);

        set_mode(1, 1, '0);
        random_requests(100, 0);

        // links written with base 0 now decode one frame on, and one to the last frame as a bad table pointer
        set_mode(1, 0, BASE_MAX);
        send_request(OP_XLATE, 57'h0, '0, '0, ptm_pkg::SIZE_4K);
        send_request(OP_MAP, 57'h0, 52'h1000, 64'h1, ptm_pkg::SIZE_4K);
        random_requests(80, 1);

        set_mode(0, 1, '0);
        random_requests(120, 0);

        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ptm_pkg.sv
rtl/core/ptm_if.sv
rtl/core/ptm_datapath.sv
rtl/core/ptm_ctrl.sv
rtl/core/page_table_map_and_translate_core.sv
tb/tb.sv
